// File: sv/g4nms_pkg.sv
// Shared constants and types for the four-row grid non-adjacent maximum sum block.
package g4nms_pkg;

   localparam int NUM_ROWS     = 4;
   localparam int NUM_PATTERNS = 8;

   typedef logic [NUM_ROWS-1:0] row_set_type;

   localparam row_set_type ROW_SETS [NUM_PATTERNS] = '{
      4'b0000, 4'b0001, 4'b0010, 4'b0100, 4'b1000, 4'b0101, 4'b1001, 4'b1010
   };

endpackage

// File: sv/g4nms_req_if.sv
// Column beat channel: four cell values and the last-column mark.
interface g4nms_req_if #(
   parameter int CELL_BITS = 32
);
   logic                        valid;
   logic                        ready;
   logic signed [CELL_BITS-1:0] cell_row0;
   logic signed [CELL_BITS-1:0] cell_row1;
   logic signed [CELL_BITS-1:0] cell_row2;
   logic signed [CELL_BITS-1:0] cell_row3;
   logic                        last_column;

   modport source (
      output valid, cell_row0, cell_row1, cell_row2, cell_row3, last_column,
      input  ready
   );

   modport sink (
      input  valid, cell_row0, cell_row1, cell_row2, cell_row3, last_column,
      output ready
   );
endinterface

// File: sv/g4nms_rsp_if.sv
// Result beat channel: best selection sum of one grid.
interface g4nms_rsp_if #(
   parameter int SCORE_BITS = 50
);
   logic                         valid;
   logic                         ready;
   logic signed [SCORE_BITS-1:0] best_sum;

   modport source (
      output valid, best_sum,
      input  ready
   );

   modport sink (
      input  valid, best_sum,
      output ready
   );
endinterface

// File: sv/g4nms_dp.sv
// Column input register, per-pattern score update and end-of-grid snapshot register.
module g4nms_dp import g4nms_pkg::*; #(
   parameter int CELL_BITS  = 32,
   parameter int SCORE_BITS = 50
) (
   input  logic                         clock,
   input  logic                         reset,
   g4nms_req_if.sink                    req_chan,
   output logic                         snap_valid,
   input  logic                         snap_ready,
   output logic signed [SCORE_BITS-1:0] snap_score [NUM_PATTERNS],
   output logic [NUM_PATTERNS-1:0]      snap_live,
   output logic signed [CELL_BITS-1:0]  snap_largest,
   output logic                         snap_positive
);

   localparam int WIDE_BITS =
      ((SCORE_BITS > CELL_BITS + 1) ? SCORE_BITS : CELL_BITS + 1) + 1;

   localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
   localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
   localparam logic signed [CELL_BITS-1:0]  CELL_MIN  = {1'b1, {(CELL_BITS-1){1'b0}}};

   function automatic logic [SCORE_BITS:0] pair_max(input logic [SCORE_BITS:0] a,
                                                    input logic [SCORE_BITS:0] b);
      logic take_b;
      take_b = b[SCORE_BITS] && (!a[SCORE_BITS] ||
               ($signed(b[SCORE_BITS-1:0]) > $signed(a[SCORE_BITS-1:0])));
      return take_b ? b : a;
   endfunction

   function automatic logic signed [CELL_BITS-1:0] cell_max(
      input logic signed [CELL_BITS-1:0] a,
      input logic signed [CELL_BITS-1:0] b);
      return (b > a) ? b : a;
   endfunction

   logic                         in_valid_ff, in_valid_in;
   logic signed [CELL_BITS-1:0]  in_cell_ff [NUM_ROWS];
   logic                         in_last_ff;
   logic                         accept;
   logic                         take;
   logic                         snap_free;

   logic signed [SCORE_BITS-1:0] score_ff [NUM_PATTERNS];
   logic signed [SCORE_BITS-1:0] score_in [NUM_PATTERNS];
   logic [NUM_PATTERNS-1:0]      score_live_ff, score_live_in;
   logic signed [CELL_BITS-1:0]  largest_ff, largest_in;
   logic                         positive_ff, positive_in;

   logic                         snap_valid_ff, snap_valid_in;
   logic signed [SCORE_BITS-1:0] snap_score_ff [NUM_PATTERNS];
   logic [NUM_PATTERNS-1:0]      snap_live_ff;
   logic signed [CELL_BITS-1:0]  snap_largest_ff;
   logic                         snap_positive_ff;

   logic [SCORE_BITS:0]          lvl0 [NUM_PATTERNS][8];
   logic [SCORE_BITS:0]          lvl1 [NUM_PATTERNS][4];
   logic [SCORE_BITS:0]          lvl2 [NUM_PATTERNS][2];
   logic [SCORE_BITS:0]          prev_best [NUM_PATTERNS];
   logic signed [WIDE_BITS-1:0]  gain [NUM_PATTERNS];
   logic signed [WIDE_BITS-1:0]  sum_w [NUM_PATTERNS];
   logic signed [CELL_BITS-1:0]  col_max01, col_max23, col_max;
   logic                         col_positive;

   assign snap_free      = !snap_valid_ff || snap_ready;
   assign take           = in_valid_ff && (!in_last_ff || snap_free);
   assign req_chan.ready = !in_valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_valid_in    = accept || (in_valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_cell_ff[0] <= req_chan.cell_row0;
         in_cell_ff[1] <= req_chan.cell_row1;
         in_cell_ff[2] <= req_chan.cell_row2;
         in_cell_ff[3] <= req_chan.cell_row3;
         in_last_ff    <= req_chan.last_column;
      end
   end

   always_comb begin
      for (int m2 = 0; m2 < NUM_PATTERNS; m2++) begin
         for (int m1 = 0; m1 < NUM_PATTERNS; m1++) begin
            lvl0[m2][m1] = {score_live_ff[m1] && ((ROW_SETS[m1] & ROW_SETS[m2]) == '0),
                            score_ff[m1]};
         end
         for (int i = 0; i < 4; i++) begin
            lvl1[m2][i] = pair_max(lvl0[m2][2*i], lvl0[m2][2*i+1]);
         end
         for (int i = 0; i < 2; i++) begin
            lvl2[m2][i] = pair_max(lvl1[m2][2*i], lvl1[m2][2*i+1]);
         end
         prev_best[m2] = pair_max(lvl2[m2][0], lvl2[m2][1]);

         gain[m2] = '0;
         for (int r = 0; r < NUM_ROWS; r++) begin
            if (ROW_SETS[m2][r]) begin
               gain[m2] = gain[m2] + WIDE_BITS'(in_cell_ff[r]);
            end
         end
         sum_w[m2] = WIDE_BITS'($signed(prev_best[m2][SCORE_BITS-1:0])) + gain[m2];
         if (sum_w[m2] > WIDE_BITS'(SCORE_MAX)) begin
            score_in[m2] = SCORE_MAX;
         end else if (sum_w[m2] < WIDE_BITS'(SCORE_MIN)) begin
            score_in[m2] = SCORE_MIN;
         end else begin
            score_in[m2] = sum_w[m2][SCORE_BITS-1:0];
         end
         score_live_in[m2] = prev_best[m2][SCORE_BITS];
      end
   end

   assign col_max01 = cell_max(in_cell_ff[0], in_cell_ff[1]);
   assign col_max23 = cell_max(in_cell_ff[2], in_cell_ff[3]);
   assign col_max   = cell_max(col_max01, col_max23);
   assign largest_in = cell_max(largest_ff, col_max);

   always_comb begin
      col_positive = 1'b0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         col_positive = col_positive ||
                        (!in_cell_ff[r][CELL_BITS-1] && (in_cell_ff[r] != '0));
      end
   end

   assign positive_in   = positive_ff || col_positive;
   assign snap_valid_in = (take && in_last_ff) || (snap_valid_ff && !snap_ready);

   always_ff @(posedge clock) begin
      if (reset || (take && in_last_ff)) begin
         for (int m = 0; m < NUM_PATTERNS; m++) begin
            score_ff[m] <= '0;
         end
         score_live_ff <= NUM_PATTERNS'(1);
         largest_ff    <= CELL_MIN;
         positive_ff   <= 1'b0;
      end else if (take) begin
         score_ff      <= score_in;
         score_live_ff <= score_live_in;
         largest_ff    <= largest_in;
         positive_ff   <= positive_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
      end
      if (take && in_last_ff) begin
         snap_score_ff    <= score_in;
         snap_live_ff     <= score_live_in;
         snap_largest_ff  <= largest_in;
         snap_positive_ff <= positive_in;
      end
   end

   assign snap_valid    = snap_valid_ff;
   assign snap_score    = snap_score_ff;
   assign snap_live     = snap_live_ff;
   assign snap_largest  = snap_largest_ff;
   assign snap_positive = snap_positive_ff;

   a_grid_restart: assert property (@(posedge clock) disable iff (reset)
      take && in_last_ff |=> (score_live_ff == NUM_PATTERNS'(1)) && !positive_ff)
      else $error("pattern state not restarted after last column");

   a_empty_live: assert property (@(posedge clock) disable iff (reset)
      score_live_ff[0])
      else $error("empty pattern lost its score");

   a_snap_live: assert property (@(posedge clock) disable iff (reset)
      snap_valid_ff |-> (snap_live_ff == {NUM_PATTERNS{1'b1}}))
      else $error("snapshot holds a pattern with no score");

endmodule

// File: sv/g4nms_pick.sv
// Best-pattern selection and result register.
module g4nms_pick import g4nms_pkg::*; #(
   parameter int CELL_BITS  = 32,
   parameter int SCORE_BITS = 50
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         snap_valid,
   output logic                         snap_ready,
   input  logic signed [SCORE_BITS-1:0] snap_score [NUM_PATTERNS],
   input  logic [NUM_PATTERNS-1:0]      snap_live,
   input  logic signed [CELL_BITS-1:0]  snap_largest,
   input  logic                         snap_positive,
   g4nms_rsp_if.source                  rsp_chan
);

   localparam int WIDE_BITS =
      ((SCORE_BITS > CELL_BITS + 1) ? SCORE_BITS : CELL_BITS + 1) + 1;

   function automatic logic [SCORE_BITS:0] pair_max(input logic [SCORE_BITS:0] a,
                                                    input logic [SCORE_BITS:0] b);
      logic take_b;
      take_b = b[SCORE_BITS] && (!a[SCORE_BITS] ||
               ($signed(b[SCORE_BITS-1:0]) > $signed(a[SCORE_BITS-1:0])));
      return take_b ? b : a;
   endfunction

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [SCORE_BITS-1:0] rsp_sum_ff, rsp_sum_in;
   logic                         load;
   logic [SCORE_BITS:0]          lvl0 [8];
   logic [SCORE_BITS:0]          lvl1 [4];
   logic [SCORE_BITS:0]          lvl2 [2];
   logic [SCORE_BITS:0]          best;
   logic signed [WIDE_BITS-1:0]  largest_w;

   assign snap_ready   = !rsp_valid_ff || rsp_chan.ready;
   assign load         = snap_valid && snap_ready;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_chan.ready);

   always_comb begin
      for (int m = 0; m < NUM_PATTERNS; m++) begin
         lvl0[m] = {snap_live[m] || (m == 0), snap_score[m]};
      end
      for (int i = 0; i < 4; i++) begin
         lvl1[i] = pair_max(lvl0[2*i], lvl0[2*i+1]);
      end
      for (int i = 0; i < 2; i++) begin
         lvl2[i] = pair_max(lvl1[2*i], lvl1[2*i+1]);
      end
      best = pair_max(lvl2[0], lvl2[1]);
   end

   assign largest_w  = WIDE_BITS'(snap_largest);
   assign rsp_sum_in = snap_positive ? best[SCORE_BITS-1:0] : largest_w[SCORE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         rsp_sum_ff <= rsp_sum_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.best_sum = rsp_sum_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_positive_sum: assert property (@(posedge clock) disable iff (reset)
      load && snap_positive |=> !rsp_sum_ff[SCORE_BITS-1] && (rsp_sum_ff != '0))
      else $error("grid with a positive cell gave a sum that is not positive");

endmodule

// File: sv/grid4_nonadjacent_max_sum.sv
// Top level: four-row grid non-adjacent maximum sum.
// Throughput: one column beat per cycle, except that a last column beat waits in the
//    input register until the snapshot register is free; pattern scores are registered
//    as each beat is taken. Result path: snapshot register, then result register.
// Each grid gives one result beat; state restarts on the cycle after its last column.
// Reset: synchronous, active high; clears all valid flags and restarts the scores.
module grid4_nonadjacent_max_sum import g4nms_pkg::*; #(
   parameter int CELL_BITS  = 32,
   parameter int SCORE_BITS = 50
) (
   input  logic          clock,
   input  logic          reset,
   g4nms_req_if.sink     req_chan,
   g4nms_rsp_if.source   rsp_chan
);

   logic                         snap_valid;
   logic                         snap_ready;
   logic signed [SCORE_BITS-1:0] snap_score [NUM_PATTERNS];
   logic [NUM_PATTERNS-1:0]      snap_live;
   logic signed [CELL_BITS-1:0]  snap_largest;
   logic                         snap_positive;

   g4nms_dp #(
      .CELL_BITS  (CELL_BITS),
      .SCORE_BITS (SCORE_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .snap_valid    (snap_valid),
      .snap_ready    (snap_ready),
      .snap_score    (snap_score),
      .snap_live     (snap_live),
      .snap_largest  (snap_largest),
      .snap_positive (snap_positive)
   );

   g4nms_pick #(
      .CELL_BITS  (CELL_BITS),
      .SCORE_BITS (SCORE_BITS)
   ) u_pick (
      .clock         (clock),
      .reset         (reset),
      .snap_valid    (snap_valid),
      .snap_ready    (snap_ready),
      .snap_score    (snap_score),
      .snap_live     (snap_live),
      .snap_largest  (snap_largest),
      .snap_positive (snap_positive),
      .rsp_chan      (rsp_chan)
   );

endmodule
